@@ hw/rtl/fbpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fbpa_pkg: shared types and constants for the fixed block pool allocator
// Field widths, register indexes, opcodes, status codes and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  // Field and register widths
  localparam int BLOCK_SIZE_W = 12;
  localparam int MAX_BLOCKS_W = 9;
  localparam int POOL_SIZE_W  = 20;
  localparam int FIELD_W      = 20;
  localparam int STATUS_W     = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 20;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BLOCKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE  = 2'd2;

  // Configuration reset values
  localparam logic [BLOCK_SIZE_W-1:0] BLOCK_SIZE_RST = 12'd64;
  localparam logic [MAX_BLOCKS_W-1:0] MAX_BLOCKS_RST = 9'd256;
  localparam logic [POOL_SIZE_W-1:0]  POOL_SIZE_RST  = 20'hFFFFF;

  // Request opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OOM      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;      // capture request word and config snapshot
    logic mul;       // form block product, read top of free stack
    logic mod_step;  // one restoring remainder step
    logic finish;    // commit counters/stack, load result register
  } dp_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic op_free;   // captured request is a free
    logic mod_last;  // last remainder step
  } dp_sts_t;

endpackage

@@ hw/rtl/fbpa_ctrl.sv @@
// ----------------------------------------------------------------------------
// fbpa_ctrl: request sequencer
// Steps one request through capture, multiply, remainder and commit, and
// owns both handshakes and the result valid flag.
// ----------------------------------------------------------------------------
module fbpa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output fbpa_pkg::dp_cmd_t cmd,
  input  fbpa_pkg::dp_sts_t sts
);
  import fbpa_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_MOD  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  // result register can take a word when empty or being drained now
  assign slot_free = !out_valid_r || !out_stall;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = sts.op_free ? S_MOD : S_FIN;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.finish ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ hw/rtl/fbpa_dp.sv @@
// ----------------------------------------------------------------------------
// fbpa_dp: allocator datapath
// Config registers, high-water and free-stack counters, free-stack memory,
// block-offset multiplier, bit-serial alignment remainder and result register.
// ----------------------------------------------------------------------------
module fbpa_dp #(
  parameter int MAX_BLOCKS  = 256,
  parameter int NODE_BYTES  = 8,
  parameter int OFFSET_BITS = 20
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               in_op,
  input  logic [fbpa_pkg::FIELD_W-1:0]       in_free_offset,
  input  fbpa_pkg::dp_cmd_t                  cmd,
  output fbpa_pkg::dp_sts_t                  sts,
  output logic [fbpa_pkg::FIELD_W-1:0]       out_block_offset,
  output logic [fbpa_pkg::STATUS_W-1:0]      out_status
);
  import fbpa_pkg::*;

  localparam int AW     = $clog2(MAX_BLOCKS);
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int PROD_W = CNT_W + BLOCK_SIZE_W;
  localparam int WIDE_W = PROD_W + OFFSET_BITS + FIELD_W;
  localparam int MC_W   = $clog2(OFFSET_BITS);

  // config registers
  logic [BLOCK_SIZE_W-1:0] block_size_r;
  logic [MAX_BLOCKS_W-1:0] max_blocks_r;
  logic [POOL_SIZE_W-1:0]  pool_size_r;

  // request snapshot
  logic                    op_r;
  logic [OFFSET_BITS-1:0]  f_r;
  logic [OFFSET_BITS-1:0]  start_r;
  logic [BLOCK_SIZE_W-1:0] bs_r;
  logic [CNT_W-1:0]        effmax_r;

  // allocator state
  logic [CNT_W-1:0]        hwc_r, hwc_nxt;
  logic [CNT_W-1:0]        depth_r, depth_nxt;
  logic [OFFSET_BITS-1:0]  mem [MAX_BLOCKS];
  logic [OFFSET_BITS-1:0]  rd_data_r;

  // arithmetic
  logic [PROD_W-1:0]       prod_r;
  logic [OFFSET_BITS-1:0]  diff_r;
  logic [BLOCK_SIZE_W-1:0] rem_r, rem_nxt;
  logic [MC_W-1:0]         mcnt_r;

  // result register
  logic [FIELD_W-1:0]      res_off_r;
  logic [STATUS_W-1:0]     res_st_r;

  // combinational helpers
  logic [BLOCK_SIZE_W-1:0] bs_eff;
  logic [CNT_W-1:0]        eff_max;
  logic [WIDE_W-1:0]       start_wide, fin_wide, calc_wide, res_wide;
  logic [OFFSET_BITS-1:0]  start_cur, f_in, calc_off, res_off;
  logic [CNT_W-1:0]        mul_a, hwc_dec;
  logic [AW-1:0]           rd_idx;
  logic [CNT_W-1:0]        depth_m1;
  logic [BLOCK_SIZE_W:0]   rem_shift, bs_ext;
  logic                    bad_chk, depth_full, push;
  logic [STATUS_W-1:0]     res_st;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r <= BLOCK_SIZE_RST;
      max_blocks_r <= MAX_BLOCKS_RST;
      pool_size_r  <= POOL_SIZE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLOCK_SIZE: block_size_r <= cfg_wdata[BLOCK_SIZE_W-1:0];
        CFG_MAX_BLOCKS: max_blocks_r <= cfg_wdata[MAX_BLOCKS_W-1:0];
        CFG_POOL_SIZE:  pool_size_r  <= cfg_wdata[POOL_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // effective config: zero block size acts as one, block count saturates
  assign bs_eff  = (block_size_r == '0) ? BLOCK_SIZE_W'(1) : block_size_r;
  assign eff_max = (32'(max_blocks_r) > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                         : CNT_W'(max_blocks_r);
  // data area starts after the node table
  assign start_wide = WIDE_W'(eff_max) * WIDE_W'(NODE_BYTES);
  assign start_cur  = start_wide[OFFSET_BITS-1:0];
  assign fin_wide   = WIDE_W'(in_free_offset);
  assign f_in       = fin_wide[OFFSET_BITS-1:0];

  // free touches block hwc-1, allocate hands out block hwc
  assign hwc_dec  = hwc_r - CNT_W'(1);
  assign mul_a    = op_r ? hwc_dec : hwc_r;
  assign depth_m1 = depth_r - CNT_W'(1);
  assign rd_idx   = depth_m1[AW-1:0];

  // restoring remainder step
  assign bs_ext    = {1'b0, bs_r};
  assign rem_shift = {rem_r, diff_r[OFFSET_BITS-1]};
  assign rem_nxt   = (rem_shift >= bs_ext) ? BLOCK_SIZE_W'(rem_shift - bs_ext)
                                           : rem_shift[BLOCK_SIZE_W-1:0];

  // request snapshot, product and remainder iteration
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_op;
      f_r      <= f_in;
      start_r  <= start_cur;
      bs_r     <= bs_eff;
      effmax_r <= eff_max;
      diff_r   <= f_in - start_cur;
      rem_r    <= '0;
      mcnt_r   <= MC_W'(OFFSET_BITS - 1);
    end else if (cmd.mod_step) begin
      rem_r  <= rem_nxt;
      diff_r <= diff_r << 1;
      mcnt_r <= mcnt_r - MC_W'(1);
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(mul_a) * PROD_W'(bs_r);
    end
  end

  // free-stack memory: pop read, push write
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      rd_data_r <= mem[rd_idx];
    end
    if (cmd.finish && push) begin
      mem[depth_r[AW-1:0]] <= f_r;
    end
  end

  assign sts.op_free  = (op_r == OP_FREE);
  assign sts.mod_last = (mcnt_r == '0);

  // block offset from product
  assign calc_wide  = WIDE_W'(prod_r) + WIDE_W'(start_r);
  assign calc_off   = calc_wide[OFFSET_BITS-1:0];
  assign bad_chk    = (f_r < start_r) || (WIDE_W'(f_r) >= WIDE_W'(pool_size_r)) ||
                      (hwc_r == '0) || (rem_r != '0);
  assign depth_full = (32'(depth_r) >= 32'(MAX_BLOCKS));

  // commit decision
  always_comb begin
    hwc_nxt   = hwc_r;
    depth_nxt = depth_r;
    push      = 1'b0;
    res_off   = '0;
    res_st    = ST_OK;
    if (op_r == OP_ALLOC) begin
      if (depth_r != '0) begin
        depth_nxt = depth_m1;
        res_off   = rd_data_r;
      end else if (hwc_r >= effmax_r) begin
        res_st = ST_OOM;
      end else begin
        res_off = calc_off;
        hwc_nxt = hwc_r + CNT_W'(1);
      end
    end else if (bad_chk) begin
      res_st = ST_BAD_FREE;
    end else if (f_r == calc_off) begin
      // topmost block: lower the mark, clear both when they meet
      if (depth_r == hwc_dec) begin
        hwc_nxt   = '0;
        depth_nxt = '0;
      end else begin
        hwc_nxt = hwc_dec;
      end
    end else if (depth_full) begin
      res_st = ST_BAD_FREE;
    end else begin
      push      = 1'b1;
      depth_nxt = depth_r + CNT_W'(1);
    end
  end

  assign res_wide = WIDE_W'(res_off);

  // counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hwc_r   <= '0;
      depth_r <= '0;
    end else if (cmd.finish) begin
      hwc_r   <= hwc_nxt;
      depth_r <= depth_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_off_r <= res_wide[FIELD_W-1:0];
      res_st_r  <= res_st;
    end
  end

  assign out_block_offset = res_off_r;
  assign out_status       = res_st_r;

endmodule

@@ hw/rtl/fixed_block_pool_allocator.sv @@
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator: fixed-size block pool with a free stack
// Hands out and takes back equal-size blocks as byte offsets from the pool
// base, reusing freed blocks first and bumping a high-water mark otherwise.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): in_op 0 allocates, 1 frees the block
//   at in_free_offset. Each request word yields exactly one result word.
//   Result channel (out_valid/out_stall): out_block_offset and out_status
//   (0 ok, 1 out of memory, 2 invalid free); offset is 0 unless an allocate
//   succeeds.
//   Config port: cfg_we writes cfg_wdata to register cfg_index (0 block size,
//   1 block count, 2 pool size); write only while no request is in flight.
//   Sequencing: an allocate goes from accept through capture, multiply and
//   commit; a free adds the bit-serial alignment remainder, which retires
//   one offset bit per cycle, before commit. One request is in flight at a
//   time; the next word is taken the cycle after the result is loaded,
//   even while it is stalled.
//   Reset (rst_n low, synchronous): config returns to 64 / 256 / 0xFFFFF, both
//   counters clear; the free-stack memory is not cleared.
//   Out stall: the result holds; a finished request waits in its last step
//   until the output register frees up.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator #(
  parameter int MAX_BLOCKS  = 256,
  parameter int NODE_BYTES  = 8,
  parameter int OFFSET_BITS = 20
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_op,
  input  logic [fbpa_pkg::FIELD_W-1:0]       in_free_offset,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [fbpa_pkg::FIELD_W-1:0]       out_block_offset,
  output logic [fbpa_pkg::STATUS_W-1:0]      out_status
);
  import fbpa_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  fbpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  fbpa_dp #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .NODE_BYTES  (NODE_BYTES),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_op            (in_op),
    .in_free_offset   (in_free_offset),
    .cmd              (cmd),
    .sts              (sts),
    .out_block_offset (out_block_offset),
    .out_status       (out_status)
  );

  // commit always presents a result next cycle
  a_finish_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid)
    else $error("result word missing after commit");

  // commit never overwrites a stalled result
  a_finish_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid || !out_stall))
    else $error("commit while result register is held");

  // no datapath work while the input side is open
  a_idle_no_work: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !(cmd.mul || cmd.mod_step || cmd.finish))
    else $error("datapath busy while accepting requests");

  // capture is always followed by the multiply step
  a_load_then_mul: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.mul)
    else $error("multiply step skipped after capture");

endmodule
